// ----- src/line_resampler_bilinear_box_unit_assert.svh -----
// assertion helpers for the line resampler, clocked on clk and disabled by rst
`ifndef LINE_RESAMPLER_BILINEAR_BOX_UNIT_ASSERT_SVH
`define LINE_RESAMPLER_BILINEAR_BOX_UNIT_ASSERT_SVH

// same-cycle implication
`define LRBB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lrbb assertion failed");

// next-cycle implication
`define LRBB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lrbb assertion failed");

`endif

// ----- src/lrbb_pkg.sv -----
`default_nettype none
package lrbb_pkg;

  // fixed point
  localparam int FRAC_BITS = 16;
  localparam logic [16:0] ONE_FX = 17'h10000;
  localparam logic [29:0] THIRD_FX = 30'd21845;
  localparam logic [29:0] POS_MAX = 30'h3FFFFFFF;

  // line limits
  localparam logic [12:0] MAX_LINE = 13'd4096;
  localparam int UPSCALE_SHIFT = 5;
  localparam int DIV_STEPS = 8;

  // register map
  localparam logic [1:0] REG_SRC_LEN = 2'd0;
  localparam logic [1:0] REG_DST_LEN = 2'd1;
  localparam logic [1:0] REG_STEP = 2'd2;
  localparam logic [1:0] REG_INV_STEP = 2'd3;

  // register reset values
  localparam logic [12:0] SRC_LEN_RESET = 13'd1;
  localparam logic [12:0] DST_LEN_RESET = 13'd1;
  localparam logic [28:0] STEP_RESET = 29'd65536;
  localparam logic [21:0] INV_STEP_RESET = 22'd65536;

  // result source select
  typedef enum logic [1:0] {
    SEL_PIXEL  = 2'd0,
    SEL_INTERP = 2'd1,
    SEL_BOX    = 2'd2
  } lrbb_sel_t;

  typedef struct packed {
    logic      accept;
    logic      put;
    lrbb_sel_t put_sel;
    logic      advance;
    logic      dn_acc;
    logic      div_start;
    logic      push_last;
    logic      finish;
  } lrbb_cmd_t;

  typedef struct packed {
    logic mode_eq;
    logic mode_up;
    logic idx_zero;
    logic last;
    logic can_put;
    logic out_free;
    logic hold_valid;
    logic fill_go;
    logic up0_go;
    logic upi_go;
    logic rem_ge;
    logic rem_eq;
    logic div_done;
  } lrbb_stat_t;

endpackage
`default_nettype wire

// ----- src/lrbb_boxdiv.sv -----
`default_nettype none
module lrbb_boxdiv (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [39:0] sum_red,
  input  logic [39:0] sum_green,
  input  logic [39:0] sum_blue,
  input  logic [39:0] sum_alpha,
  input  logic [29:0] weight,
  input  logic [21:0] inv_step,
  output logic        done,
  output logic [7:0]  q_red,
  output logic [7:0]  q_green,
  output logic [7:0]  q_blue,
  output logic [7:0]  q_alpha
);
  import lrbb_pkg::*;

  logic [2:0][39:0] rem;
  logic [2:0][7:0]  quo;
  logic [36:0]      dsh;
  logic [2:0]       cnt;
  logic             busy;
  logic             wzero;
  logic [39:0]      sum_a;
  logic [61:0]      acc;

  // restoring division, one quotient bit per cycle on three lanes, alpha scale alongside
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      rem[0] <= sum_red;
      rem[1] <= sum_green;
      rem[2] <= sum_blue;
      quo <= '0;
      dsh <= {weight, 7'b0};
      wzero <= (weight == 30'd0);
      sum_a <= sum_alpha;
      acc <= 62'({22'b0, sum_alpha} * {51'b0, inv_step[10:0]});
      cnt <= '0;
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      for (int k = 0; k < 3; k++) begin
        if (rem[k] >= {3'b0, dsh}) begin
          rem[k] <= rem[k] - {3'b0, dsh};
          quo[k] <= {quo[k][6:0], 1'b1};
        end else begin
          quo[k] <= {quo[k][6:0], 1'b0};
        end
      end
      dsh <= dsh >> 1;
      if (cnt == 3'd0) begin
        acc <= acc + (62'({22'b0, sum_a} * {51'b0, inv_step[21:11]}) << 11);
      end
      cnt <= cnt + 3'd1;
      if (cnt == 3'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // zero covered area gives zero colour
  assign q_red = wzero ? 8'd0 : quo[0];
  assign q_green = wzero ? 8'd0 : quo[1];
  assign q_blue = wzero ? 8'd0 : quo[2];
  assign q_alpha = (|acc[61:40]) ? 8'hFF : acc[39:32];

endmodule
`default_nettype wire

// ----- src/lrbb_datapath.sv -----
`default_nettype none
module lrbb_datapath (
  input  logic               clk,
  input  logic               rst,
  input  lrbb_pkg::lrbb_cmd_t  cmd,
  output lrbb_pkg::lrbb_stat_t stat,
  input  logic [12:0]        src_len,
  input  logic [12:0]        dst_len,
  input  logic [28:0]        step,
  input  logic [21:0]        inv_step,
  input  logic [7:0]         in_red,
  input  logic [7:0]         in_green,
  input  logic [7:0]         in_blue,
  input  logic [7:0]         in_alpha,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic [7:0]         out_alpha,
  output logic               last_of_run,
  output logic               end_of_line,
  output logic               out_valid,
  input  logic               out_ready
);
  import lrbb_pkg::*;

  logic [12:0]      src_idx;
  logic [12:0]      tgt;
  logic [29:0]      pos;
  logic [3:0][7:0]  prev;
  logic [3:0][7:0]  px;
  logic [3:0][39:0] sums;
  logic [29:0]      cw;
  logic [29:0]      remw;
  logic [16:0]      left;
  logic [6:0]       n_out;
  logic [3:0][7:0]  hold;
  logic             hold_valid;
  logic [3:0][7:0]  out_data;

  logic [12:0]      s_eff;
  logic [12:0]      d_lim;
  logic [17:0]      d_cap;
  logic [12:0]      d_eff;
  logic             last;
  logic [28:0]      lim;
  logic [29:0]      w;
  logic [16:0]      frac;
  logic [16:0]      inv_frac;
  logic [25:0]      isum [4];
  logic [3:0][7:0]  ival;
  logic [30:0]      pos_sum;
  logic [29:0]      pos_adv;
  logic [16:0]      mult;
  logic [39:0]      addv [4];
  logic [3:0][7:0]  put_val;
  logic             out_free;
  logic             fill_go;
  logic             bd_done;
  logic [7:0]       bd_red;
  logic [7:0]       bd_green;
  logic [7:0]       bd_blue;
  logic [7:0]       bd_alpha;

  // effective line lengths
  always_comb begin
    s_eff = (src_len == 13'd0) ? 13'd1 : ((src_len > MAX_LINE) ? MAX_LINE : src_len);
    d_lim = (dst_len == 13'd0) ? 13'd1 : ((dst_len > MAX_LINE) ? MAX_LINE : dst_len);
    d_cap = {5'b0, s_eff} << UPSCALE_SHIFT;
    d_eff = ({5'b0, d_lim} > d_cap) ? d_cap[12:0] : d_lim;
    last = (src_idx >= s_eff - 13'd1);
    lim = {s_eff - 13'd1, 16'b0};
  end

  // interpolation between previous and current pixel
  always_comb begin
    w = pos - THIRD_FX;
    frac = {1'b0, w[FRAC_BITS-1:0]};
    inv_frac = ONE_FX - frac;
    for (int k = 0; k < 4; k++) begin
      isum[k] = ({18'b0, prev[k]} * {9'b0, inv_frac}) + ({18'b0, px[k]} * {9'b0, frac});
      ival[k] = (|isum[k][25:24]) ? 8'hFF : isum[k][23:16];
    end
  end

  // position advance, saturating
  always_comb begin
    pos_sum = {1'b0, pos} + {2'b0, step};
    pos_adv = pos_sum[30] ? POS_MAX : pos_sum[29:0];
  end

  // box area covered by this pixel
  always_comb begin
    mult = (remw < {13'b0, left}) ? remw[16:0] : left;
    for (int k = 0; k < 4; k++) begin
      addv[k] = {32'b0, px[k]} * {23'b0, mult};
    end
  end

  // result select
  always_comb begin
    case (cmd.put_sel)
      SEL_PIXEL: put_val = px;
      SEL_INTERP: put_val = ival;
      SEL_BOX: put_val = {bd_alpha, bd_blue, bd_green, bd_red};
      default: put_val = px;
    endcase
  end

  // status to the controller
  always_comb begin
    out_free = !out_valid || out_ready;
    fill_go = (tgt < d_eff) && !n_out[6];
    stat.mode_eq = (d_eff == s_eff);
    stat.mode_up = (d_eff > s_eff);
    stat.idx_zero = (src_idx == 13'd0);
    stat.last = last;
    stat.can_put = !hold_valid || out_free;
    stat.out_free = out_free;
    stat.hold_valid = hold_valid;
    stat.fill_go = fill_go;
    stat.up0_go = fill_go && (pos < THIRD_FX);
    stat.upi_go = fill_go && (pos >= THIRD_FX) && (w < {1'b0, lim})
                  && (w[29:16] < {1'b0, src_idx});
    stat.rem_ge = (remw >= {13'b0, left});
    stat.rem_eq = (remw == {13'b0, left});
    stat.div_done = bd_done;
  end

  lrbb_boxdiv u_boxdiv (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .sum_red   (sums[0]),
    .sum_green (sums[1]),
    .sum_blue  (sums[2]),
    .sum_alpha (sums[3]),
    .weight    (cw),
    .inv_step  (inv_step),
    .done      (bd_done),
    .q_red     (bd_red),
    .q_green   (bd_green),
    .q_blue    (bd_blue),
    .q_alpha   (bd_alpha)
  );

  // line state, box sums, hold stage and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      src_idx <= '0;
      tgt <= '0;
      pos <= '0;
      prev <= '0;
      sums <= '0;
      cw <= '0;
      remw <= {1'b0, STEP_RESET};
      left <= ONE_FX;
      n_out <= '0;
      hold_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // output register fills from the hold stage or drains on a handshake
      if ((cmd.put && hold_valid) || cmd.push_last) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      // new request: line start reloads
      if (cmd.accept) begin
        px <= {in_alpha, in_blue, in_green, in_red};
        n_out <= '0;
        left <= ONE_FX;
        if (src_idx == 13'd0) begin
          tgt <= '0;
          pos <= '0;
          sums <= '0;
          cw <= '0;
          remw <= {1'b0, step};
        end
      end
      // one result into the hold stage
      if (cmd.put) begin
        if (hold_valid) begin
          out_data <= hold;
          last_of_run <= 1'b0;
          end_of_line <= 1'b0;
        end
        hold <= put_val;
        hold_valid <= 1'b1;
        tgt <= tgt + 13'd1;
        n_out <= n_out + 7'd1;
        if (cmd.advance) begin
          pos <= pos_adv;
        end
        if (cmd.put_sel == SEL_BOX) begin
          sums <= '0;
          cw <= '0;
          remw <= {1'b0, step};
        end
      end
      // final result of the request
      if (cmd.push_last) begin
        out_data <= hold;
        last_of_run <= 1'b1;
        end_of_line <= last;
        hold_valid <= 1'b0;
      end
      // box accumulation
      if (cmd.dn_acc) begin
        if (px[3] != 8'd0) begin
          for (int k = 0; k < 3; k++) begin
            sums[k] <= sums[k] + addv[k];
          end
          cw <= cw + {13'b0, mult};
        end
        sums[3] <= sums[3] + addv[3];
        if (remw >= {13'b0, left}) begin
          remw <= remw - {13'b0, left};
        end else begin
          left <= left - remw[16:0];
          remw <= '0;
        end
      end
      // end of request
      if (cmd.finish) begin
        prev <= px;
        if (last) begin
          src_idx <= '0;
          tgt <= '0;
          pos <= '0;
          sums <= '0;
          cw <= '0;
          remw <= {1'b0, step};
        end else begin
          src_idx <= src_idx + 13'd1;
        end
      end
    end
  end

  assign out_red = out_data[0];
  assign out_green = out_data[1];
  assign out_blue = out_data[2];
  assign out_alpha = out_data[3];

endmodule
`default_nettype wire

// ----- src/lrbb_ctrl.sv -----
`default_nettype none
`include "line_resampler_bilinear_box_unit_assert.svh"
module lrbb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lrbb_pkg::lrbb_stat_t st,
  output lrbb_pkg::lrbb_cmd_t  cmd
);
  import lrbb_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_EQ    = 10'b0000000010,
    S_UP0   = 10'b0000000100,
    S_UPI   = 10'b0000001000,
    S_UPL   = 10'b0000010000,
    S_DN    = 10'b0000100000,
    S_DNL   = 10'b0001000000,
    S_DIVGO = 10'b0010000000,
    S_DIVW  = 10'b0100000000,
    S_END   = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   ret_loop;
  logic   ret_loop_next;

  // sequencing of one request
  always_comb begin
    state_next = state;
    ret_loop_next = ret_loop;
    cmd = '0;
    cmd.put_sel = SEL_PIXEL;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (st.mode_eq) begin
            state_next = S_EQ;
          end else if (st.mode_up) begin
            state_next = st.idx_zero ? S_UP0 : S_UPI;
          end else begin
            state_next = S_DN;
          end
        end
      end
      S_EQ: begin
        if (st.can_put) begin
          cmd.put = 1'b1;
          state_next = S_END;
        end
      end
      S_UP0: begin
        if (st.up0_go) begin
          if (st.can_put) begin
            cmd.put = 1'b1;
            cmd.advance = 1'b1;
          end
        end else begin
          state_next = st.last ? S_UPL : S_END;
        end
      end
      S_UPI: begin
        if (st.upi_go) begin
          if (st.can_put) begin
            cmd.put = 1'b1;
            cmd.put_sel = SEL_INTERP;
            cmd.advance = 1'b1;
          end
        end else begin
          state_next = st.last ? S_UPL : S_END;
        end
      end
      S_UPL: begin
        if (st.fill_go) begin
          if (st.can_put) begin
            cmd.put = 1'b1;
            cmd.advance = 1'b1;
          end
        end else begin
          state_next = S_END;
        end
      end
      S_DN: begin
        if (st.fill_go) begin
          cmd.dn_acc = 1'b1;
          if (!st.rem_ge) begin
            ret_loop_next = 1'b1;
            state_next = S_DIVGO;
          end else if (st.rem_eq) begin
            ret_loop_next = 1'b0;
            state_next = S_DIVGO;
          end else begin
            state_next = st.last ? S_DNL : S_END;
          end
        end else begin
          state_next = st.last ? S_DNL : S_END;
        end
      end
      S_DNL: begin
        if (st.fill_go) begin
          ret_loop_next = 1'b0;
          state_next = S_DIVGO;
        end else begin
          state_next = S_END;
        end
      end
      S_DIVGO: begin
        cmd.div_start = 1'b1;
        state_next = S_DIVW;
      end
      S_DIVW: begin
        if (st.div_done && st.can_put) begin
          cmd.put = 1'b1;
          cmd.put_sel = SEL_BOX;
          if (ret_loop) begin
            state_next = S_DN;
          end else begin
            state_next = st.last ? S_DNL : S_END;
          end
        end
      end
      S_END: begin
        if (!st.hold_valid) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else if (st.out_free) begin
          cmd.push_last = 1'b1;
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret_loop <= 1'b0;
    end else begin
      state <= state_next;
      ret_loop <= ret_loop_next;
    end
  end

  `LRBB_ASSERT_IMP(a_put_has_room, cmd.put, st.can_put)
  `LRBB_ASSERT_IMP(a_push_has_hold, cmd.push_last, st.hold_valid && st.out_free)
  `LRBB_ASSERT_NXT(a_accept_leaves_idle, in_valid && in_ready, state != S_IDLE)

endmodule
`default_nettype wire

// ----- src/line_resampler_bilinear_box_unit.sv -----
`default_nettype none
// sequence: equal lengths accept, put and finish a request; copying or interpolating
// accepts, puts each result, fills on the final pixel of a line; output stalls hold puts
// box average: each target pixel waits for the 8-step restoring divider
// requests: one at a time, and a new request is taken while the final result still
// waits in the output register
// reset: synchronous active-high rst clears control state and loads register defaults
module line_resampler_bilinear_box_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_alpha,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic        last_of_run,
  output logic        end_of_line
);
  import lrbb_pkg::*;

  logic [12:0] src_len;
  logic [12:0] dst_len;
  logic [28:0] step;
  logic [21:0] inv_step;
  lrbb_cmd_t   cmd;
  lrbb_stat_t  stat;

  assign pready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      src_len <= SRC_LEN_RESET;
      dst_len <= DST_LEN_RESET;
      step <= STEP_RESET;
      inv_step <= INV_STEP_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_SRC_LEN: src_len <= pwdata[12:0];
        REG_DST_LEN: dst_len <= pwdata[12:0];
        REG_STEP: step <= pwdata[28:0];
        REG_INV_STEP: inv_step <= pwdata[21:0];
        default: src_len <= src_len;
      endcase
    end
  end

  // configuration reads
  always_comb begin
    case (paddr[3:2])
      REG_SRC_LEN: prdata = {19'b0, src_len};
      REG_DST_LEN: prdata = {19'b0, dst_len};
      REG_STEP: prdata = {3'b0, step};
      REG_INV_STEP: prdata = {10'b0, inv_step};
      default: prdata = '0;
    endcase
  end

  lrbb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (stat),
    .cmd      (cmd)
  );

  lrbb_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .src_len     (src_len),
    .dst_len     (dst_len),
    .step        (step),
    .inv_step    (inv_step),
    .in_red      (in_red),
    .in_green    (in_green),
    .in_blue     (in_blue),
    .in_alpha    (in_alpha),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .out_alpha   (out_alpha),
    .last_of_run (last_of_run),
    .end_of_line (end_of_line),
    .out_valid   (out_valid),
    .out_ready   (out_ready)
  );

endmodule
`default_nettype wire

// ----- test/lrbb_checker.sv -----
`default_nettype none
module lrbb_checker
  import lrbb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_alpha,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_red,
  input  logic [7:0]  out_green,
  input  logic [7:0]  out_blue,
  input  logic [7:0]  out_alpha,
  input  logic        last_of_run,
  input  logic        end_of_line,
  output int          errors,
  output int          pending,
  output int          compared
);

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       run_end;
    logic       line_end;
  } target_px_t;

  localparam int RUN_CAP = 64;
  localparam int LINE_CAP = 4096;
  localparam int UPSCALE_MAX = 32;

  target_px_t target_q[$];

  // shadow registers
  longint unsigned src_len, dst_len, step, inv_step;

  // line state
  longint unsigned src_idx, tgt_idx, pos, sum_w, remain_w;
  longint unsigned sums[4];
  logic [7:0] prev_px[4];
  int run_count;

  function automatic logic [7:0] sat8(longint unsigned v);
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  task automatic put_target(longint unsigned r, longint unsigned g,
                            longint unsigned b, longint unsigned a);
    target_px_t t;
    t.red = sat8(r);
    t.green = sat8(g);
    t.blue = sat8(b);
    t.alpha = sat8(a);
    t.run_end = 1'b0;
    t.line_end = 1'b0;
    target_q.push_back(t);
    run_count++;
    tgt_idx++;
  endtask

  task automatic advance_pos();
    pos = pos + step;
    if (pos > POS_MAX) pos = POS_MAX;
  endtask

  task automatic clear_box();
    for (int k = 0; k < 4; k++) sums[k] = 0;
    sum_w = 0;
  endtask

  // box average of the accumulated span
  task automatic emit_box();
    longint unsigned c[3];
    for (int k = 0; k < 3; k++) c[k] = (sum_w != 0) ? sums[k] / sum_w : 0;
    put_target(c[0], c[1], c[2], (sums[3] * inv_step) >> (2 * FRAC_BITS));
    clear_box();
    remain_w = step;
  endtask

  task automatic restart_line();
    tgt_idx = 0;
    pos = 0;
    clear_box();
    remain_w = step;
  endtask

  // work out the target pixels one source pixel completes
  task automatic resample_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                logic [7:0] a);
    longint unsigned s, d, lim, w, f, left, rem, mult;
    longint unsigned px[4], v[4];
    bit is_last;
    bit stop;
    px[0] = r; px[1] = g; px[2] = b; px[3] = a;
    s = (src_len == 0) ? 1 : src_len;
    if (s > LINE_CAP) s = LINE_CAP;
    d = (dst_len == 0) ? 1 : dst_len;
    if (d > LINE_CAP) d = LINE_CAP;
    if (d > UPSCALE_MAX * s) d = UPSCALE_MAX * s;
    is_last = (src_idx >= s - 1);
    run_count = 0;
    if (src_idx == 0) restart_line();

    if (d == s) begin
      put_target(px[0], px[1], px[2], px[3]);
    end else if (d > s) begin
      lim = (s - 1) << FRAC_BITS;
      if (src_idx == 0)
        while (tgt_idx < d && run_count < RUN_CAP && pos < THIRD_FX) begin
          put_target(px[0], px[1], px[2], px[3]);
          advance_pos();
        end
      if (src_idx > 0) begin
        stop = 0;
        while (!stop && tgt_idx < d && run_count < RUN_CAP && pos >= THIRD_FX) begin
          w = pos - THIRD_FX;
          if (w >= lim || (w >> FRAC_BITS) >= src_idx) begin
            stop = 1;
          end else begin
            f = w & (ONE_FX - 1);
            for (int k = 0; k < 4; k++)
              v[k] = (prev_px[k] * (ONE_FX - f) + px[k] * f) >> FRAC_BITS;
            put_target(v[0], v[1], v[2], v[3]);
            advance_pos();
          end
        end
      end
      if (is_last)
        while (tgt_idx < d && run_count < RUN_CAP) begin
          put_target(px[0], px[1], px[2], px[3]);
          advance_pos();
        end
    end else begin
      left = ONE_FX;
      stop = 0;
      while (!stop && tgt_idx < d && run_count < RUN_CAP) begin
        rem = remain_w;
        mult = (rem < left) ? rem : left;
        if (px[3] != 0) begin
          for (int k = 0; k < 3; k++) sums[k] += px[k] * mult;
          sum_w += mult;
        end
        sums[3] += px[3] * mult;
        if (rem >= left) begin
          remain_w = rem - left;
          if (remain_w == 0) emit_box();
          stop = 1;
        end else begin
          left -= rem;
          remain_w = 0;
          emit_box();
        end
      end
      if (is_last)
        while (tgt_idx < d && run_count < RUN_CAP) emit_box();
    end

    if (run_count > 0) begin
      target_q[$].run_end = 1'b1;
      if (is_last) target_q[$].line_end = 1'b1;
    end
    for (int k = 0; k < 4; k++) prev_px[k] = px[k][7:0];
    if (is_last) begin
      src_idx = 0;
      restart_line();
    end else begin
      src_idx++;
    end
  endtask

  // compare one accepted target pixel with the oldest prediction
  task automatic check_target();
    target_px_t t;
    int exp_f[6], act_f[6];
    string names[6];
    names = '{"red", "green", "blue", "alpha", "last_of_run", "end_of_line"};
    compared++;
    if (target_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected target pixel r=%0d g=%0d b=%0d a=%0d", $time,
               out_red, out_green, out_blue, out_alpha);
      return;
    end
    t = target_q.pop_front();
    exp_f = '{t.red, t.green, t.blue, t.alpha, t.run_end, t.line_end};
    act_f = '{out_red, out_green, out_blue, out_alpha, last_of_run, end_of_line};
    for (int k = 0; k < 6; k++)
      if (exp_f[k] != act_f[k]) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, names[k],
                 exp_f[k], act_f[k]);
      end
  endtask

  initial begin
    errors = 0;
    compared = 0;
  end

  assign pending = target_q.size();

  // watch configuration writes and both pixel channels
  always @(posedge clk) begin
    if (rst) begin
      src_len = SRC_LEN_RESET;
      dst_len = DST_LEN_RESET;
      step = STEP_RESET;
      inv_step = INV_STEP_RESET;
      src_idx = 0;
      for (int k = 0; k < 4; k++) prev_px[k] = 8'd0;
      restart_line();
    end else begin
      if (psel && penable && pwrite && pready)
        case (paddr[3:2])
          REG_SRC_LEN:  src_len = pwdata[12:0];
          REG_DST_LEN:  dst_len = pwdata[12:0];
          REG_STEP:     step = pwdata[28:0];
          REG_INV_STEP: inv_step = pwdata[21:0];
          default: ;
        endcase
      if (out_valid && out_ready) check_target();
      if (in_valid && in_ready) resample_pixel(in_red, in_green, in_blue, in_alpha);
    end
  end

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
`default_nettype none
module testbench;
  import lrbb_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_red = '0, in_green = '0, in_blue = '0, in_alpha = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_red, out_green, out_blue, out_alpha;
  logic        last_of_run, end_of_line;

  int errors, pending, compared;
  int pixels_sent = 0;
  int settings_used = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_count = 0;

  line_resampler_bilinear_box_unit DUT (.*);

  lrbb_checker checker_i (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #30000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver stalls: a randomly drawn mode sets out_ready
  always @(posedge clk) begin
    stall_count <= stall_count + 1;
    if (stall_count % 64 == 0) stall_mode <= int'($urandom_range(0, 3));
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (stall_count % 4 == 0);
      default: out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_ratio(int unsigned s, int unsigned d, int unsigned st,
                           int unsigned inv);
    reg_write(REG_SRC_LEN, s);
    reg_write(REG_DST_LEN, d);
    reg_write(REG_STEP, st);
    reg_write(REG_INV_STEP, inv);
    settings_used++;
    @(posedge clk);
  endtask

  // one source pixel request, sent in bursts with random gaps
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    in_alpha <= a;
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
  endtask

  task automatic send_random_pixel();
    logic [7:0] a;
    a = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
    send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), a);
  endtask

  task automatic send_lines(int unsigned s, int lines);
    repeat (lines * ((s == 0) ? 1 : s)) send_random_pixel();
  endtask

  // wait until the block is idle before the next register change
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic ratio_phase(int unsigned s, int unsigned d, int lines);
    set_ratio(s, d, (s << 16) / d, (d << 16) / s);
    send_lines(s, lines);
    drain();
  endtask

  initial begin
    int unsigned s, d, st, inv;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // pass-through with channel extremes
    set_ratio(4, 4, 65536, 65536);
    send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0, 8'd255);
    drain();

    // largest upscale with its matching step and inverse step
    set_ratio(2, 64, 2048, 2097152);
    send_pixel(8'd10, 8'd200, 8'd0, 8'd255);
    send_pixel(8'd250, 8'd0, 8'd128, 8'd1);
    drain();

    // downscale with transparent pixels in the box
    set_ratio(8, 2, 262144, 16384);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd0);
    send_pixel(8'd100, 8'd50, 8'd25, 8'd255);
    repeat (6) send_random_pixel();
    drain();

    // huge step: everything lands in the flush; smallest inverse step
    set_ratio(8, 2, 268435456, 16);
    send_lines(8, 1);
    drain();

    // zero lengths act as one
    set_ratio(0, 0, 65536, 65536);
    send_lines(1, 2);
    drain();

    // lengths past the maximum, then shrink the line mid-way
    set_ratio(8191, 8191, 65536, 65536);
    repeat (3) send_random_pixel();
    drain();
    set_ratio(4, 200, 1310, 3276800 & 32'h3FFFFF);
    send_lines(1, 1);
    drain();

    // uneven ratios
    ratio_phase(3, 7, 2);
    ratio_phase(5, 3, 2);

    // random settings, mostly consistent ratios
    while (pixels_sent < 200) begin
      s = $urandom_range(1, 10);
      d = ($urandom_range(0, 3) == 0) ? s : $urandom_range(1, 40);
      st = (s << 16) / d;
      inv = (d << 16) / s;
      if ($urandom_range(0, 4) == 0) begin
        st = $urandom_range(2048, 300000);
        inv = $urandom_range(16, 200000);
      end
      set_ratio(s, d, st, inv);
      send_lines(s, $urandom_range(1, 3));
      drain();
    end

    $display("covered %0d source pixels under %0d register settings", pixels_sent,
             settings_used);
    $display("compared %0d target pixels against the predictor", compared);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
